/* rtl/ttc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table cache package
// Shared operation codes, entry payload layout and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ttc_pkg;

	// Default number of table entries; must be a power of two.
	localparam int unsigned TTC_ENTRIES = 1024;

	// Operation codes carried by func.
	typedef enum logic [1:0] {
		FN_PROBE = 2'd0,
		FN_STORE = 2'd1,
		FN_CLEAR = 2'd2,
		FN_AGE   = 2'd3
	} func_t;

	// Payload stored beside each key, most significant field first.
	typedef struct packed {
		logic [7:0]  age;
		logic [1:0]  bound;
		logic [15:0] mv;
		logic [15:0] score;
		logic [6:0]  depth;
	} pay_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input beat and read its entry
		logic sweep;     // zero the key at the sweep counter and advance it
		logic sweep_pay; // also zero the payload at the sweep counter
		logic exec;      // finish the captured item and load the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last; // the sweep counter points at the last entry
		logic sweep_busy; // the sweep counter is away from entry zero
		logic item_clear; // the beat on the input asks for a clear
	} sts_t;

endpackage

/* rtl/transposition_table_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table cache
// Direct-mapped table of position hashes with probe, store, clear and age
// operations; one result beat for every input beat.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | func, key, search_depth, value, move_code,
//          |                      | bound_kind
//  output  | out_valid / out_stall| hit, hit_depth, hit_value, hit_move, hit_bound
//
// Probe, store and age read the entry from the memory port in the accept
// cycle, then decide and write it back once the output register is free.
// Clear zeroes one key per cycle through the single write port and then
// returns its result the same way. After reset a sweep zeroes keys and
// payloads; in_stall stays high until it ends.
// One item is in work at a time; a finished result waits in the output
// register while the next beat is accepted, and a result stalled on the
// output holds the following item in its final cycle.
// ----------------------------------------------------------------------------
module transposition_table_cache #(
	parameter int unsigned ENTRIES = ttc_pkg::TTC_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [63:0]        key,
	input  logic [6:0]         search_depth,
	input  logic signed [15:0] value,
	input  logic [15:0]        move_code,
	input  logic [1:0]         bound_kind,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [6:0]         hit_depth,
	output logic signed [15:0] hit_value,
	output logic [15:0]        hit_move,
	output logic [1:0]         hit_bound
);

	ttc_pkg::cmd_t cmd;
	ttc_pkg::sts_t sts;

	// Controller.
	ttc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath with the table memories.
	ttc_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.key          (key),
		.search_depth (search_depth),
		.value        (value),
		.move_code    (move_code),
		.bound_kind   (bound_kind),
		.hit          (hit),
		.hit_depth    (hit_depth),
		.hit_value    (hit_value),
		.hit_move     (hit_move),
		.hit_bound    (hit_bound)
	);

`ifndef SYNTHESIS
	// An accepted beat keeps the input stalled in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted beat");

	// A new result only appears from a cycle in which the input was stalled.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// While a sweep is under way no beat is accepted.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sweep_busy |-> in_stall)
		else $error("input open during a memory sweep");

	// A stored non-hit result never reports payload bits.
	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (hit_depth == 7'd0 && hit_move == 16'd0 &&
		hit_bound == 2'd0 && hit_value == 16'sd0))
		else $error("miss result carries nonzero fields");
`endif

endmodule

/* rtl/ttc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table cache controller
// Sequences the reset sweep, single-item lookups and updates, the clear sweep
// and the output handshake.
// ----------------------------------------------------------------------------
module ttc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ttc_pkg::sts_t sts,
	output ttc_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	// The result register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep     = 1'b1;
				cmd.sweep_pay = 1'b1;
			end
			ST_IDLE: begin
				cmd.load = accept;
			end
			ST_EXEC: begin
				cmd.exec = out_free;
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sts.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= sts.item_clear ? ST_CLEAR : ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					if (sts.sweep_last) begin
						state_q <= ST_EXEC;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

endmodule

/* rtl/ttc_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table cache datapath
// Holds the key and payload memories, the current age, the sweep counter,
// the captured input beat and the result register.
// ----------------------------------------------------------------------------
module ttc_dpath #(
	parameter int unsigned ENTRIES = ttc_pkg::TTC_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ttc_pkg::cmd_t       cmd,
	output ttc_pkg::sts_t       sts,
	input  logic [1:0]          func,
	input  logic [63:0]         key,
	input  logic [6:0]          search_depth,
	input  logic signed [15:0]  value,
	input  logic [15:0]         move_code,
	input  logic [1:0]          bound_kind,
	output logic                hit,
	output logic [6:0]          hit_depth,
	output logic signed [15:0]  hit_value,
	output logic [15:0]         hit_move,
	output logic [1:0]          hit_bound
);

	localparam int unsigned IDX_W = $clog2(ENTRIES);

	// Table storage.
	logic [63:0]   key_mem [ENTRIES];
	ttc_pkg::pay_t pay_mem [ENTRIES];

	// Captured item and registered read data.
	logic [1:0]       func_q;
	logic [63:0]      key_q;
	logic [6:0]       depth_q;
	logic [15:0]      score_q;
	logic [15:0]      move_q;
	logic [1:0]       bound_q;
	logic [63:0]      key_rd_q;
	ttc_pkg::pay_t    pay_rd_q;

	// Control state kept here.
	logic [7:0]       age_q;
	logic [IDX_W-1:0] sweep_cnt_q;

	logic [IDX_W-1:0] idx_q;
	logic             is_probe;
	logic             is_store;
	logic             is_age;
	logic             probe_hit;
	logic             replace;
	ttc_pkg::pay_t    new_pay;

	assign idx_q    = key_q[IDX_W-1:0];
	assign is_probe = (func_q == ttc_pkg::FN_PROBE);
	assign is_store = (func_q == ttc_pkg::FN_STORE);
	assign is_age   = (func_q == ttc_pkg::FN_AGE);

	// Hit and replacement decisions on the entry read at capture.
	assign probe_hit = (key_rd_q == key_q) && (pay_rd_q.age == age_q);
	assign replace   = (key_rd_q == 64'd0) || (pay_rd_q.depth <= depth_q) ||
		(pay_rd_q.age != age_q);

	always_comb begin
		new_pay.age   = age_q;
		new_pay.bound = bound_q;
		new_pay.mv    = move_q;
		new_pay.score = score_q;
		new_pay.depth = depth_q;
	end

	assign sts.sweep_last = &sweep_cnt_q;
	assign sts.sweep_busy = |sweep_cnt_q;
	assign sts.item_clear = (func == ttc_pkg::FN_CLEAR);

	// Capture the input beat and read its entry in the same cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			key_q    <= key;
			depth_q  <= search_depth;
			score_q  <= value;
			move_q   <= move_code;
			bound_q  <= bound_kind;
			key_rd_q <= key_mem[key[IDX_W-1:0]];
			pay_rd_q <= pay_mem[key[IDX_W-1:0]];
		end
	end

	// Single write port per memory: sweep zeroing or a store that wins.
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			key_mem[sweep_cnt_q] <= 64'd0;
			if (cmd.sweep_pay) begin
				pay_mem[sweep_cnt_q] <= '0;
			end
		end else if (cmd.exec && is_store && replace) begin
			key_mem[idx_q] <= key_q;
			pay_mem[idx_q] <= new_pay;
		end
	end

	// Current age and sweep counter; the counter wraps back to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q       <= 8'd0;
			sweep_cnt_q <= '0;
		end else begin
			if (cmd.exec && is_age) begin
				age_q <= age_q + 8'd1;
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= sweep_cnt_q + {{(IDX_W-1){1'b0}}, 1'b1};
			end
		end
	end

	// Result register; fields are zero unless a probe hits.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_probe && probe_hit) begin
				hit       <= 1'b1;
				hit_depth <= pay_rd_q.depth;
				hit_value <= pay_rd_q.score;
				hit_move  <= pay_rd_q.mv;
				hit_bound <= pay_rd_q.bound;
			end else begin
				hit       <= 1'b0;
				hit_depth <= 7'd0;
				hit_value <= 16'sd0;
				hit_move  <= 16'd0;
				hit_bound <= 2'd0;
			end
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table cache testbench
// Sends probe, store, clear and age beats, including a full age wrap, while
// the sender and receiver idle at random. A behavioral copy of the table
// predicts every result beat, and each beat is checked field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned ENTRIES     = ttc_pkg::TTC_ENTRIES;
	localparam int          IDX_W       = $clog2(ENTRIES);
	localparam int          POOL        = 16;
	localparam int          PHASE_ITEMS = 152;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          CYCLE_LIMIT = 400000;

	// One input beat and one result beat.
	typedef struct {
		ttc_pkg::func_t     func;
		logic [63:0]        key;
		logic [6:0]         depth;
		logic signed [15:0] value;
		logic [15:0]        move;
		logic [1:0]         bound;
	} tt_beat_t;

	typedef struct {
		logic               hit;
		logic [6:0]         depth;
		logic signed [15:0] value;
		logic [15:0]        move;
		logic [1:0]         bound;
	} tt_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = ttc_pkg::FN_PROBE;
	logic [63:0]        key = '0;
	logic [6:0]         search_depth = '0;
	logic signed [15:0] value = '0;
	logic [15:0]        move_code = '0;
	logic [1:0]         bound_kind = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic [6:0]         hit_depth;
	logic signed [15:0] hit_value;
	logic [15:0]        hit_move;
	logic [1:0]         hit_bound;

	// Predicted table contents.
	logic [63:0]   tt_key[ENTRIES];
	ttc_pkg::pay_t tt_pay[ENTRIES];
	logic [7:0]    tt_age;

	tt_beat_t    tt_cmd_q[$];
	tt_result_t  tt_results_q[$];
	logic [63:0] key_pool[POOL];

	tt_beat_t    drv_beat;
	tt_beat_t    seen_beat;
	tt_result_t  want;
	logic        beat_taken = 1'b0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          hits_seen = 0;
	int          clears_done = 0;
	int          ages_done = 0;
	int          cycle_count = 0;

	transposition_table_cache #(.ENTRIES(ENTRIES)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.key          (key),
		.search_depth (search_depth),
		.value        (value),
		.move_code    (move_code),
		.bound_kind   (bound_kind),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.hit_depth    (hit_depth),
		.hit_value    (hit_value),
		.hit_move     (hit_move),
		.hit_bound    (hit_bound)
	);

	always #2 clk = ~clk;

	// Apply one beat to the predicted table and return its result.
	function automatic tt_result_t tt_apply(tt_beat_t b);
		tt_result_t       r;
		logic [IDX_W-1:0] idx;
		ttc_pkg::pay_t    p;
		r = '{hit: 1'b0, depth: '0, value: '0, move: '0, bound: '0};
		idx = b.key[IDX_W-1:0];
		p = tt_pay[idx];
		case (b.func)
			ttc_pkg::FN_PROBE: begin
				if (tt_key[idx] == b.key && p.age == tt_age) begin
					r.hit   = 1'b1;
					r.depth = p.depth;
					r.value = p.score;
					r.move  = p.mv;
					r.bound = p.bound;
				end
			end
			ttc_pkg::FN_STORE: begin
				if (tt_key[idx] == '0 || p.depth <= b.depth || p.age != tt_age) begin
					tt_key[idx] = b.key;
					tt_pay[idx] = '{age: tt_age, bound: b.bound, mv: b.move,
						score: b.value, depth: b.depth};
				end
			end
			ttc_pkg::FN_CLEAR: begin
				foreach (tt_key[i])
					tt_key[i] = '0;
				clears_done++;
			end
			default: begin
				tt_age = tt_age + 8'd1;
				ages_done++;
			end
		endcase
		return r;
	endfunction

	task automatic push_beat(ttc_pkg::func_t f, logic [63:0] k, logic [6:0] d,
			logic [15:0] v, logic [15:0] m, logic [1:0] bk);
		tt_beat_t b;
		b.func  = f;
		b.key   = k;
		b.depth = d;
		b.value = v;
		b.move  = m;
		b.bound = bk;
		tt_cmd_q.insert(tt_cmd_q.size(), b);
	endtask

	// Mostly reuse recent keys so probes hit; fresh keys crowd a few slots.
	function automatic logic [63:0] pick_key();
		int          sel;
		int          slot;
		logic [63:0] k;
		sel = $urandom_range(0, 99);
		slot = $urandom_range(0, POOL - 1);
		if (sel < 55)
			return key_pool[slot];
		k = {$urandom, $urandom};
		if (sel < 90)
			k[IDX_W-1:0] = IDX_W'($urandom_range(0, 15));
		key_pool[slot] = k;
		return k;
	endfunction

	task automatic push_random_beat();
		int             sel;
		ttc_pkg::func_t f;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			f = ttc_pkg::FN_PROBE;
		else if (sel < 85)
			f = ttc_pkg::FN_STORE;
		else if (sel < 97)
			f = ttc_pkg::FN_AGE;
		else
			f = ttc_pkg::FN_CLEAR;
		push_beat(f, pick_key(), 7'($urandom_range(0, 127)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			2'($urandom_range(0, 3)));
	endtask

	// Input driver: a new beat only once the previous one has gone.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || beat_taken)) begin
			if (tt_cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_beat = tt_cmd_q.pop_front();
				in_valid     <= 1'b1;
				func         <= drv_beat.func;
				key          <= drv_beat.key;
				search_depth <= drv_beat.depth;
				value        <= drv_beat.value;
				move_code    <= drv_beat.move;
				bound_kind   <= drv_beat.bound;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Monitor: check each result beat, then predict the accepted input beat.
	always @(posedge clk) begin
		beat_taken <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (tt_results_q.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				want = tt_results_q.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					mismatches++;
				end
				if (hit_depth !== want.depth) begin
					$error("hit_depth: expected %0d, got %0d", want.depth, hit_depth);
					mismatches++;
				end
				if (hit_value !== want.value) begin
					$error("hit_value: expected %0d, got %0d", want.value, hit_value);
					mismatches++;
				end
				if (hit_move !== want.move) begin
					$error("hit_move: expected %0d, got %0d", want.move, hit_move);
					mismatches++;
				end
				if (hit_bound !== want.bound) begin
					$error("hit_bound: expected %0d, got %0d", want.bound, hit_bound);
					mismatches++;
				end
				if (want.hit)
					hits_seen++;
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			seen_beat.func  = ttc_pkg::func_t'(func);
			seen_beat.key   = key;
			seen_beat.depth = search_depth;
			seen_beat.value = value;
			seen_beat.move  = move_code;
			seen_beat.bound = bound_kind;
			tt_results_q.insert(tt_results_q.size(), tt_apply(seen_beat));
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", CYCLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		int ph;
		foreach (tt_key[i]) begin
			tt_key[i] = '0;
			tt_pay[i] = '0;
		end
		tt_age = '0;
		key_pool[0] = '0;
		for (n = 1; n < POOL; n++)
			key_pool[n] = {$urandom, 28'($urandom), 4'(n)};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed beats: key zero, extremes, replacement rules, age and clear.
		push_beat(ttc_pkg::FN_PROBE, '0, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_PROBE, '1, 7'h7F, 16'hFFFF, 16'hFFFF, 2'd3);
		push_beat(ttc_pkg::FN_STORE, '1, 7'h7F, 16'h8000, 16'hFFFF, 2'd3);
		push_beat(ttc_pkg::FN_PROBE, '1, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_STORE, 64'h3FF, 7'd0, 16'h1111, 16'h2222, 2'd1);
		push_beat(ttc_pkg::FN_PROBE, 64'h3FF, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_STORE, '1, 7'h7F, 16'h7FFF, 16'h0000, 2'd0);
		push_beat(ttc_pkg::FN_PROBE, '1, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_AGE, '1, 7'h7F, 16'hFFFF, 16'hFFFF, 2'd3);
		push_beat(ttc_pkg::FN_PROBE, '1, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_STORE, 64'h3FF, 7'd0, 16'h1234, 16'h5678, 2'd2);
		push_beat(ttc_pkg::FN_PROBE, 64'h3FF, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_PROBE, '0, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_STORE, 64'h8000_0000_0000_0000, 7'd5, 16'hABCD, 16'h00FF,
			2'd1);
		push_beat(ttc_pkg::FN_CLEAR, '1, 7'h7F, 16'hFFFF, 16'hFFFF, 2'd3);
		push_beat(ttc_pkg::FN_PROBE, 64'h8000_0000_0000_0000, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_PROBE, '0, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_STORE, 64'h400, 7'd0, 16'h0001, 16'h8000, 2'd0);
		push_beat(ttc_pkg::FN_PROBE, 64'h400, '0, '0, '0, 2'd0);
		push_beat(ttc_pkg::FN_STORE, '0, 7'd3, 16'hFFFE, 16'h7FFF, 2'd2);
		push_beat(ttc_pkg::FN_PROBE, '0, '0, '0, '0, 2'd0);

		// Random beats under three idling patterns.
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// A full turn of the age counter, then look for the old entries again.
			if (ph == 1) begin
				for (n = 0; n < 256; n++)
					push_beat(ttc_pkg::FN_AGE, {$urandom, $urandom},
						7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
				for (n = 0; n < POOL; n++)
					push_beat(ttc_pkg::FN_PROBE, key_pool[n], '0, '0, '0, 2'd0);
			end
			for (n = 0; n < PHASE_ITEMS; n++)
				push_random_beat();
			while (tt_cmd_q.size() != 0)
				@(posedge clk);
		end

		// Let the last beats go through and the results drain.
		while (in_valid || tt_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d result beats, %0d of them probe hits.", results_seen, hits_seen);
		$display("The table saw %0d clears and %0d age steps.", clears_done, ages_done);
		if (mismatches == 0 && tt_results_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
